@@ rtl/fcc_pkg.sv @@
// Shared types, constants and entry classification for the cluster chain engine.
package fcc_pkg;

    // Table geometry.
    localparam int FAT_ENTRIES = 65536;
    localparam int FAT_ADDR_W  = $clog2(FAT_ENTRIES);
    localparam int ENTRY_W     = 32;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Field widths.
    localparam int CLASS_W    = 3;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 17;
    localparam int OFFSET_W   = 63;
    localparam int CBYTES_W   = 36;

    // Raw entry code boundaries.
    localparam logic [ENTRY_W-1:0] ENT_FREE_MAX = 32'h0000_0001;
    localparam logic [ENTRY_W-1:0] ENT_RSVD_LO  = 32'h0FFF_FFF0;
    localparam logic [ENTRY_W-1:0] ENT_RSVD_HI  = 32'h0FFF_FFF6;
    localparam logic [ENTRY_W-1:0] ENT_BAD      = 32'h0FFF_FFF7;
    localparam logic [ENTRY_W-1:0] ENT_EOC_MIN  = 32'h0FFF_FFF8;
    localparam logic [ENTRY_W-1:0] NEXT_EOC     = 32'hFFFF_FFFF;

    // Saturation limit of the chain byte count.
    localparam logic [CBYTES_W-1:0] CBYTES_MAX = '1;

    // Input operation codes.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESERVED_SECTORS    = 3'd0,
        CFG_FAT_COPIES          = 3'd1,
        CFG_SECTORS_PER_FAT     = 3'd2,
        CFG_SECTORS_PER_CLUSTER = 3'd3,
        CFG_BYTES_PER_SECTOR    = 3'd4
    } t_cfg_reg;

    // Entry class codes.
    typedef enum logic [CLASS_W-1:0] {
        CLS_USED   = 3'd0,
        CLS_FREE   = 3'd1,
        CLS_BAD    = 3'd2,
        CLS_END    = 3'd3,
        CLS_IDXERR = 3'd4
    } t_class;

    // Chain walk status codes.
    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FREE  = 2'd1,
        STS_BAD   = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_WALK  = 3'd1,
        ST_CALC1 = 3'd2,
        ST_CALC2 = 3'd3,
        ST_CALC3 = 3'd4,
        ST_DONE  = 3'd5
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_entry;
        logic load;
        logic mem_re;
        logic sel_link;
        logic walk_step;
        logic calc1;
        logic calc2;
        logic calc3;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;
    } t_sts;

    // Classify one raw table entry; the top four bits are not masked.
    function automatic t_class classify(input logic [ENTRY_W-1:0] v);
        t_class k;
        if (v <= ENT_FREE_MAX || (v >= ENT_RSVD_LO && v <= ENT_RSVD_HI)) begin
            k = CLS_FREE;
        end else if (v == ENT_BAD) begin
            k = CLS_BAD;
        end else if (v >= ENT_EOC_MIN) begin
            k = CLS_END;
        end else begin
            k = CLS_USED;
        end
        return k;
    endfunction

endpackage

@@ rtl/fcc_ram.sv @@
// Generic single-port RAM with registered read data.
module fcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one read per cycle, both at the shared address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fcc_ctrl.sv @@
// Controller state machine that sequences table writes, chain walks and result math.
module fcc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_operation,
    input  fcc_pkg::t_sts i_sts,
    output fcc_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_result_valid
);
    import fcc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && t_op'(i_operation) == OP_QUERY) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = ST_CALC1;
                end
            end
            ST_CALC1: n_state = ST_CALC2;
            ST_CALC2: n_state = ST_CALC3;
            ST_CALC3: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd          = '0;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (t_op'(i_operation) == OP_QUERY) begin
                        o_cmd.load   = 1'b1;
                        o_cmd.mem_re = 1'b1;
                    end else begin
                        o_cmd.write_entry = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.sel_link  = 1'b1;
                o_cmd.mem_re    = !i_sts.walk_done;
            end
            ST_CALC1: o_cmd.calc1 = 1'b1;
            ST_CALC2: o_cmd.calc2 = 1'b1;
            ST_CALC3: o_cmd.calc3 = 1'b1;
            ST_DONE:  o_result_valid = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

endmodule

@@ rtl/fcc_dpath.sv @@
// Datapath: configuration registers, table memory, chain walk and offset arithmetic.
module fcc_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic [fcc_pkg::FAT_ADDR_W-1:0]        i_cluster_index,
    input  logic [fcc_pkg::ENTRY_W-1:0]           i_entry_value,
    input  fcc_pkg::t_cmd                         i_cmd,
    output fcc_pkg::t_sts                         o_sts,
    output logic [fcc_pkg::CLASS_W-1:0]           o_entry_class,
    output logic                                  o_allocated,
    output logic [fcc_pkg::ENTRY_W-1:0]           o_next_cluster,
    output logic [fcc_pkg::OFFSET_W-1:0]          o_byte_offset,
    output logic [fcc_pkg::STATUS_W-1:0]          o_chain_status,
    output logic [fcc_pkg::COUNT_W-1:0]           o_chain_clusters,
    output logic [fcc_pkg::CBYTES_W-1:0]          o_chain_bytes
);
    import fcc_pkg::*;

    // Configuration registers.
    logic [15:0] r_reserved_sectors;
    logic [2:0]  r_fat_copies;
    logic [22:0] r_sectors_per_fat;
    logic [7:0]  r_sectors_per_cluster;
    logic [12:0] r_bytes_per_sector;

    // Walk state.
    logic [FAT_ADDR_W-1:0] r_idx;
    logic                  r_first;
    logic [COUNT_W-1:0]    r_count;
    t_status               r_status;
    t_class                r_class;
    logic [ENTRY_W-1:0]    r_next;

    // Arithmetic pipeline.
    logic [25:0]        r_fat_sec;
    logic signed [26:0] r_clus_sec;
    logic [20:0]        r_cl_bytes;
    logic signed [27:0] r_sector;
    logic [37:0]        r_prod;
    logic [39:0]        r_offset;
    logic [COUNT_W-1:0] r_clusters;
    logic [CBYTES_W-1:0] r_bytes;

    logic [ENTRY_W-1:0]    w_rd_data;
    logic [FAT_ADDR_W-1:0] w_addr;
    t_class                w_kind;
    logic                  w_done;
    t_status               w_status;
    logic signed [17:0]    w_rel_idx;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved_sectors    <= 16'd32;
            r_fat_copies          <= 3'd2;
            r_sectors_per_fat     <= 23'd512;
            r_sectors_per_cluster <= 8'd8;
            r_bytes_per_sector    <= 13'd512;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_RESERVED_SECTORS:    r_reserved_sectors    <= i_cfg_wdata[15:0];
                CFG_FAT_COPIES:          r_fat_copies          <= i_cfg_wdata[2:0];
                CFG_SECTORS_PER_FAT:     r_sectors_per_fat     <= i_cfg_wdata[22:0];
                CFG_SECTORS_PER_CLUSTER: r_sectors_per_cluster <= i_cfg_wdata[7:0];
                CFG_BYTES_PER_SECTOR:    r_bytes_per_sector    <= i_cfg_wdata[12:0];
                default: begin
                end
            endcase
        end
    end

    // The table is read at the queried cluster first, then at each link.
    assign w_addr = i_cmd.sel_link ? w_rd_data[FAT_ADDR_W-1:0] : i_cluster_index;

    fcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FAT_ENTRIES)
    ) u_fat_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_entry),
        .i_re    (i_cmd.mem_re),
        .i_addr  (w_addr),
        .i_wdata (i_entry_value),
        .o_rdata (w_rd_data)
    );

    // Evaluate the entry just read: stop on free, bad or end, or on a bad link or a loop.
    always_comb begin
        w_kind   = classify(w_rd_data);
        w_done   = 1'b1;
        w_status = STS_OK;
        case (w_kind)
            CLS_FREE: w_status = STS_FREE;
            CLS_BAD:  w_status = STS_BAD;
            CLS_END:  w_status = STS_OK;
            CLS_USED: begin
                if (w_rd_data >= ENTRY_W'(FAT_ENTRIES)) begin
                    w_status = STS_RANGE;
                end else if (r_count == COUNT_W'(FAT_ENTRIES)) begin
                    w_status = STS_RANGE;
                end else begin
                    w_done = 1'b0;
                end
            end
            default: w_status = STS_RANGE;
        endcase
    end

    assign o_sts.walk_done = w_done;

    // Walk bookkeeping; the first entry read also fills the entry fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx    <= i_cluster_index;
            r_first  <= 1'b1;
            r_count  <= COUNT_W'(1);
            r_status <= STS_OK;
        end else if (i_cmd.walk_step) begin
            r_first <= 1'b0;
            if (w_done) begin
                r_status <= w_status;
            end else begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (r_first) begin
                r_class <= w_kind;
                case (w_kind)
                    CLS_USED: r_next <= w_rd_data;
                    CLS_END:  r_next <= NEXT_EOC;
                    default:  r_next <= '0;
                endcase
            end
        end
    end

    assign w_rel_idx = $signed({2'b00, r_idx}) - 18'sd2;

    // Products of the sector and byte arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc1) begin
            r_fat_sec  <= {23'd0, r_fat_copies} * {3'd0, r_sectors_per_fat};
            r_clus_sec <= $signed({{9{w_rel_idx[17]}}, w_rel_idx})
                        * $signed({19'd0, r_sectors_per_cluster});
            r_cl_bytes <= {13'd0, r_sectors_per_cluster} * {8'd0, r_bytes_per_sector};
        end
        if (i_cmd.calc2) begin
            r_sector <= $signed({12'd0, r_reserved_sectors}) + $signed({2'b00, r_fat_sec})
                      + $signed({r_clus_sec[26], r_clus_sec});
            r_prod   <= {21'd0, r_count} * {17'd0, r_cl_bytes};
        end
        if (i_cmd.calc3) begin
            if (r_sector[27]) begin
                r_offset <= '0;
            end else begin
                r_offset <= {13'd0, r_sector[26:0]} * {27'd0, r_bytes_per_sector};
            end
            if (r_status != STS_OK) begin
                r_clusters <= '0;
                r_bytes    <= '0;
            end else begin
                r_clusters <= r_count;
                if (r_prod > {2'b00, CBYTES_MAX}) begin
                    r_bytes <= CBYTES_MAX;
                end else begin
                    r_bytes <= r_prod[CBYTES_W-1:0];
                end
            end
        end
    end

    // Result fields.
    assign o_entry_class    = r_class;
    assign o_allocated      = (r_class == CLS_USED) || (r_class == CLS_END);
    assign o_next_cluster   = r_next;
    assign o_byte_offset    = {23'd0, r_offset};
    assign o_chain_status   = r_status;
    assign o_chain_clusters = r_clusters;
    assign o_chain_bytes    = r_bytes;

endmodule

@@ rtl/fat32_cluster_chain_engine_unit.sv @@
// Timing: a write entry transfer is taken while idle and gives no result.
// A query walks the chain at one table read per link, L being the entries read (1 to
// 65536), then passes the calc1, calc2, calc3 and done states; the strobe is raised in
// the done state and start is taken again once the engine is back in idle. The single
// table port sets the walk rate. The receiver cannot stall.
// Reset (synchronous, active low) clears the controller and loads register defaults.
module fat32_cluster_chain_engine_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_cfg_we,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                  i_operation,
    input  logic [fcc_pkg::FAT_ADDR_W-1:0]        i_cluster_index,
    input  logic [fcc_pkg::ENTRY_W-1:0]           i_entry_value,
    output logic                                  o_result_valid,
    output logic [fcc_pkg::CLASS_W-1:0]           o_entry_class,
    output logic                                  o_allocated,
    output logic [fcc_pkg::ENTRY_W-1:0]           o_next_cluster,
    output logic [fcc_pkg::OFFSET_W-1:0]          o_byte_offset,
    output logic [fcc_pkg::STATUS_W-1:0]          o_chain_status,
    output logic [fcc_pkg::COUNT_W-1:0]           o_chain_clusters,
    output logic [fcc_pkg::CBYTES_W-1:0]          o_chain_bytes
);
    import fcc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    fcc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_operation    (i_operation),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    // Table, walk and arithmetic.
    fcc_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cluster_index  (i_cluster_index),
        .i_entry_value    (i_entry_value),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_entry_class    (o_entry_class),
        .o_allocated      (o_allocated),
        .o_next_cluster   (o_next_cluster),
        .o_byte_offset    (o_byte_offset),
        .o_chain_status   (o_chain_status),
        .o_chain_clusters (o_chain_clusters),
        .o_chain_bytes    (o_chain_bytes)
    );

endmodule
